@@ design/sfd_pkg.sv @@
`timescale 1ns / 1ps
package sfd_pkg;

   // receive buffer geometry
   localparam int BUF_BYTES = 64;
   localparam int ADDR_W    = $clog2(BUF_BYTES);
   localparam int CNT_W     = ADDR_W + 1;

   // frame layout
   localparam logic [7:0] SYNC_HI   = 8'hAA;
   localparam logic [7:0] SYNC_LO   = 8'h55;
   localparam int         HDR_BYTES = 6;
   localparam int         OVERHEAD  = 7;

   // input opcodes
   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // queue depth (both sides)
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   typedef struct packed {
      logic       opcode;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] msg_tag;
      logic [7:0]  frame_code;
      logic [7:0]  body_len;
      logic        has_byte;
      logic [7:0]  byte_index;
      logic [7:0]  payload_byte;
      logic        frame_end;
      logic        run_end;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN_RD,
      ST_SCAN_DT,
      ST_LEN_RD,
      ST_LEN_DT,
      ST_SUM_RD,
      ST_SUM_DT,
      ST_EMIT_RD,
      ST_EMIT_DT,
      ST_FINISH
   } eng_state_type;

endpackage

@@ design/sfd_req_queue.sv @@
`timescale 1ns / 1ps
// Front part: takes input transfers and holds them for the engine.
module sfd_req_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  sfd_pkg::req_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            valid,
   output sfd_pkg::req_type pop_data
);
   import sfd_pkg::*;

   req_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign full     = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rptr_ff];
   assign do_wr    = push && !full;
   assign do_rd    = pop && valid;

   // pointer and count update
   always_comb begin
      wptr_in = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end
endmodule

@@ design/sfd_rsp_queue.sv @@
`timescale 1ns / 1ps
// Result queue: parts the engine from the result consumer.
module sfd_rsp_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  sfd_pkg::rsp_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            empty,
   output sfd_pkg::rsp_type pop_data
);
   import sfd_pkg::*;

   rsp_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign full     = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rptr_ff];
   assign do_wr    = push && !full;
   assign do_rd    = pop && !empty;

   // pointer and count update
   always_comb begin
      wptr_in = do_wr ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_rd ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (QPTR_W+1)'(do_wr) - (QPTR_W+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end
endmodule

@@ design/sfd_engine.sv @@
`timescale 1ns / 1ps
// Back part: circular receive buffer, sync search, checksum and payload walk.
module sfd_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  sfd_pkg::req_type req_data,
   output logic            req_pop,
   input  logic            rsp_full,
   output logic            rsp_push,
   output sfd_pkg::rsp_type rsp_data
);
   import sfd_pkg::*;

   eng_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              prev_aa_ff, prev_aa_in;
   logic [7:0]        len_ff, len_in;
   logic [7:0]        sum_ff, sum_in;
   logic [15:0]       mid_ff, mid_in;
   logic [7:0]        sc_ff, sc_in;
   rsp_type           pend_ff, pend_in;
   logic              pend_vld_ff, pend_vld_in;

   logic [7:0]        mem_ff [BUF_BYTES];
   logic [7:0]        rd_data_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              wr_en;

   logic              emit;
   rsp_type           emit_data;
   logic              can_emit;
   logic              match;
   logic [CNT_W-1:0]  pos;
   logic [8:0]        total_new;
   logic [8:0]        total_cur;
   logic [7:0]        bidx;

   assign rd_addr   = head_ff + idx_ff[ADDR_W-1:0];
   assign wr_addr   = head_ff + fill_ff[ADDR_W-1:0];
   assign can_emit  = !pend_vld_ff || !rsp_full;
   assign match     = prev_aa_ff && (rd_data_ff == SYNC_LO);
   assign pos       = idx_ff - 1'b1;
   assign total_new = {1'b0, rd_data_ff} + 9'(OVERHEAD);
   assign total_cur = {1'b0, len_ff} + 9'(OVERHEAD);
   assign bidx      = 8'(idx_ff) - 8'(HDR_BYTES);

   // buffer memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= req_data.rx_byte;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_data.opcode == OP_CLEAR) ? ST_IDLE : ST_CHECK;
            end
         end
         ST_CHECK:   state_in = (fill_ff < CNT_W'(HDR_BYTES)) ? ST_FINISH : ST_SCAN_RD;
         ST_SCAN_RD: state_in = ST_SCAN_DT;
         ST_SCAN_DT: begin
            if (match) begin
               state_in = ((fill_ff - pos) < CNT_W'(HDR_BYTES)) ? ST_FINISH : ST_LEN_RD;
            end else if (idx_ff + 1'b1 == fill_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_LEN_RD: state_in = ST_LEN_DT;
         ST_LEN_DT: begin
            if (total_new > 9'(BUF_BYTES)) begin
               state_in = ST_CHECK;
            end else if ({2'b0, fill_ff} < total_new) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_SUM_RD: state_in = ST_SUM_DT;
         ST_SUM_DT: begin
            if ({2'b0, idx_ff} == total_cur - 9'd1) begin
               state_in = (sum_ff == rd_data_ff) ? ST_EMIT_RD : ST_CHECK;
            end else begin
               state_in = ST_SUM_RD;
            end
         end
         ST_EMIT_RD: begin
            if (len_ff == 8'd0) begin
               state_in = can_emit ? ST_CHECK : ST_EMIT_RD;
            end else begin
               state_in = ST_EMIT_DT;
            end
         end
         ST_EMIT_DT: begin
            if (can_emit) begin
               state_in = (bidx + 8'd1 == len_ff) ? ST_CHECK : ST_EMIT_RD;
            end
         end
         ST_FINISH: begin
            if (!pend_vld_ff || !rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and handshake outputs
   always_comb begin
      head_in     = head_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      prev_aa_in  = prev_aa_ff;
      len_in      = len_ff;
      sum_in      = sum_ff;
      mid_in      = mid_ff;
      sc_in       = sc_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      req_pop     = 1'b0;
      wr_en       = 1'b0;
      emit        = 1'b0;
      rsp_push    = 1'b0;
      rsp_data    = pend_ff;

      emit_data            = '0;
      emit_data.msg_tag    = mid_ff;
      emit_data.frame_code = sc_ff;
      emit_data.body_len   = len_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_pop = 1'b1;
               if (req_data.opcode == OP_CLEAR) begin
                  fill_in = '0;
               end else if (fill_ff < CNT_W'(BUF_BYTES)) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
         ST_CHECK: begin
            idx_in     = '0;
            prev_aa_in = 1'b0;
         end
         ST_SCAN_DT: begin
            if (match) begin
               // drop bytes before the sync word
               head_in = head_ff + pos[ADDR_W-1:0];
               fill_in = fill_ff - pos;
               idx_in  = CNT_W'(HDR_BYTES - 1);
            end else if (idx_ff + 1'b1 == fill_ff) begin
               // no sync word: keep only the newest byte
               head_in = head_ff + fill_ff[ADDR_W-1:0] - 1'b1;
               fill_in = CNT_W'(1);
            end else begin
               prev_aa_in = (rd_data_ff == SYNC_HI);
               idx_in     = idx_ff + 1'b1;
            end
         end
         ST_LEN_DT: begin
            len_in = rd_data_ff;
            idx_in = '0;
            sum_in = '0;
            if (total_new > 9'(BUF_BYTES)) begin
               head_in = head_ff + 1'b1;
               fill_in = fill_ff - 1'b1;
            end
         end
         ST_SUM_DT: begin
            if ({2'b0, idx_ff} == total_cur - 9'd1) begin
               idx_in = CNT_W'(HDR_BYTES);
               if (sum_ff != rd_data_ff) begin
                  head_in = head_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
               end
            end else begin
               sum_in = sum_ff + rd_data_ff;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == CNT_W'(2)) mid_in[15:8] = rd_data_ff;
               if (idx_ff == CNT_W'(3)) mid_in[7:0]  = rd_data_ff;
               if (idx_ff == CNT_W'(4)) sc_in        = rd_data_ff;
            end
         end
         ST_EMIT_RD: begin
            if (len_ff == 8'd0) begin
               emit                = 1'b1;
               emit_data.frame_end = 1'b1;
            end
         end
         ST_EMIT_DT: begin
            emit                   = 1'b1;
            emit_data.has_byte     = 1'b1;
            emit_data.byte_index   = bidx;
            emit_data.payload_byte = rd_data_ff;
            emit_data.frame_end    = (bidx + 8'd1 == len_ff);
            if (can_emit) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            // last result of the item leaves with run_end set
            if (pend_vld_ff && !rsp_full) begin
               rsp_push         = 1'b1;
               rsp_data.run_end = 1'b1;
               pend_vld_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase

      // hold each result one step so run_end can be set on the last one
      if (emit && can_emit) begin
         rsp_push    = pend_vld_ff;
         pend_in     = emit_data;
         pend_vld_in = 1'b1;
         if (emit_data.frame_end) begin
            head_in = head_ff + total_cur[ADDR_W-1:0];
            fill_in = fill_ff - total_cur[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         head_ff     <= '0;
         fill_ff     <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      prev_aa_ff <= prev_aa_in;
      len_ff     <= len_in;
      sum_ff     <= sum_in;
      mid_ff     <= mid_in;
      sc_ff      <= sc_in;
      pend_ff    <= pend_in;
   end
endmodule

@@ design/sync_frame_stream_deframer_core.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                   Accepted when
// input     req_push, req_full, req_opcode/rx_byte  req_push && !req_full
// result    rsp_pop, rsp_empty, rsp_* fields        rsp_pop && !rsp_empty
//
// A push pops the item, stores its byte if there is room and then checks the buffer;
// the engine scans for the sync word byte by byte, and per candidate frame reads
// the length, sums the frame bytes and checks again on a retry; a good frame then
// emits each payload byte, or one result for an empty payload, before the finish
// step. All reads use the single read port of the 64-byte circular buffer.
// Reset empties both queues and the buffer count; buffer bytes are not cleared.
// A full result queue stalls the engine; the input queue takes items until full.
module sync_frame_stream_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [15:0] rsp_msg_tag,
   output logic [7:0]  rsp_frame_code,
   output logic [7:0]  rsp_body_len,
   output logic        rsp_has_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_end,
   output logic        rsp_run_end
);
   import sfd_pkg::*;

   req_type in_item, eng_item;
   rsp_type eng_rsp, out_rsp;
   logic    eng_valid, eng_pop, eng_push, rq_full;

   assign in_item.opcode  = req_opcode;
   assign in_item.rx_byte = req_rx_byte;

   sfd_req_queue u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (in_item),
      .full      (req_full),
      .pop       (eng_pop),
      .valid     (eng_valid),
      .pop_data  (eng_item)
   );

   sfd_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (eng_valid),
      .req_data  (eng_item),
      .req_pop   (eng_pop),
      .rsp_full  (rq_full),
      .rsp_push  (eng_push),
      .rsp_data  (eng_rsp)
   );

   sfd_rsp_queue u_back (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_data (eng_rsp),
      .full      (rq_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (out_rsp)
   );

   assign rsp_msg_tag      = out_rsp.msg_tag;
   assign rsp_frame_code   = out_rsp.frame_code;
   assign rsp_body_len     = out_rsp.body_len;
   assign rsp_has_byte     = out_rsp.has_byte;
   assign rsp_byte_index   = out_rsp.byte_index;
   assign rsp_payload_byte = out_rsp.payload_byte;
   assign rsp_frame_end    = out_rsp.frame_end;
   assign rsp_run_end      = out_rsp.run_end;
endmodule

@@ design/sfd_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the result stream.
module sfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_pop,
   input logic        rsp_empty,
   input logic [7:0]  rsp_body_len,
   input logic        rsp_has_byte,
   input logic [7:0]  rsp_byte_index,
   input logic [7:0]  rsp_payload_byte,
   input logic        rsp_frame_end,
   input logic        rsp_run_end
);
   // nothing waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_payload_byte)))
      else $error("waiting result changed");

   // the empty-frame result has zero length, index and byte, and closes its frame
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_has_byte) |-> (rsp_body_len == 8'd0 &&
       rsp_byte_index == 8'd0 && rsp_payload_byte == 8'd0 && rsp_frame_end))
      else $error("bad empty-frame result");

   // a frame closes on its last payload byte
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_has_byte) |->
      (rsp_frame_end == (rsp_byte_index + 8'd1 == rsp_body_len)))
      else $error("frame_end misplaced");

   // an item's run ends on a frame boundary
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_run_end) |-> rsp_frame_end)
      else $error("run_end inside a frame");
endmodule

bind sync_frame_stream_deframer_core sfd_checker u_sfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_pop          (rsp_pop),
   .rsp_empty        (rsp_empty),
   .rsp_body_len     (rsp_body_len),
   .rsp_has_byte     (rsp_has_byte),
   .rsp_byte_index   (rsp_byte_index),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_frame_end    (rsp_frame_end),
   .rsp_run_end      (rsp_run_end)
);
